[sv/tpc_pkg.sv]
// Shared types and constants for the touch position conditioner.
`default_nettype none
package tpc_pkg;
    localparam int BASELINE_SLOTS_DEF  = 8;
    localparam int SAMPLE_BITS_DEF     = 12;
    localparam int MATCH_TOLERANCE_DEF = 128;

    localparam logic [1:0] CMD_TOUCH = 2'd0;
    localparam logic [1:0] CMD_NONE  = 2'd1;
    localparam logic [1:0] CMD_ADD   = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOSEED = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [2:0] REG_X_LOW  = 3'd0;
    localparam logic [2:0] REG_X_HIGH = 3'd1;
    localparam logic [2:0] REG_Y_LOW  = 3'd2;
    localparam logic [2:0] REG_Y_HIGH = 3'd3;
    localparam logic [2:0] REG_ORIENT = 3'd4;
    localparam logic [2:0] REG_ALPHA  = 3'd5;
    localparam logic [2:0] REG_WIDTH  = 3'd6;
    localparam logic [2:0] REG_HEIGHT = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCALE,
        S_FILT,
        S_SCAN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;      // load item, start division
        logic div_step;
        logic do_scale;
        logic do_filt;
        logic scan_step;
        logic finish;     // build result
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic scan_done;
        logic is_touch;
    } stat_t;
endpackage
`default_nettype wire

[sv/tpc_ctrl.sv]
// Controller state machine for the touch position conditioner.
`default_nettype none
module tpc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire tpc_pkg::stat_t st,
    output tpc_pkg::cmd_t      cmd
);
    tpc_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            tpc_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = tpc_pkg::S_DIV;
                end
            end
            tpc_pkg::S_DIV:
            begin
                if (!st.is_touch)
                    state_next = tpc_pkg::S_OUT;
                else if (st.div_done)
                    state_next = tpc_pkg::S_SCALE;
                else
                    cmd.div_step = 1'b1;
            end
            tpc_pkg::S_SCALE:
            begin
                cmd.do_scale = 1'b1;
                state_next   = tpc_pkg::S_FILT;
            end
            tpc_pkg::S_FILT:
            begin
                cmd.do_filt = 1'b1;
                state_next  = tpc_pkg::S_SCAN;
            end
            tpc_pkg::S_SCAN:
            begin
                if (st.scan_done)
                    state_next = tpc_pkg::S_OUT;
                else
                    cmd.scan_step = 1'b1;
            end
            tpc_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = tpc_pkg::S_IDLE;
                end
            end
            default: state_next = tpc_pkg::S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result dropped while stalled");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == tpc_pkg::S_IDLE)
        else $error("ready outside idle");
    a_finish_only_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finish without result");
endmodule
`default_nettype wire

[sv/tpc_datapath.sv]
// Datapath: normalizing divider, scaling, IIR filter, baseline store and scan.
`default_nettype none
module tpc_datapath #(
    parameter int BASELINE_SLOTS  = tpc_pkg::BASELINE_SLOTS_DEF,
    parameter int SAMPLE_BITS     = tpc_pkg::SAMPLE_BITS_DEF,
    parameter int MATCH_TOLERANCE = tpc_pkg::MATCH_TOLERANCE_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tpc_pkg::cmd_t    cmd,
    output tpc_pkg::stat_t        st,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_idx,
    input  wire logic [15:0]      cfg_data,
    output logic [31:0]           cfg_rdata,
    input  wire logic [1:0]       command,
    input  wire logic [11:0]      x_sample,
    input  wire logic [11:0]      y_sample,
    output logic                  valid_res,
    output logic [15:0]           x_pos,
    output logic [15:0]           y_pos,
    output logic [11:0]           x_echo,
    output logic [11:0]           y_echo,
    output logic [1:0]            status,
    output logic [3:0]            baseline_count
);
    localparam int SB  = SAMPLE_BITS;
    localparam int IW  = (BASELINE_SLOTS > 1) ? $clog2(BASELINE_SLOTS) : 1;
    localparam int CW  = $clog2(BASELINE_SLOTS + 1);
    localparam int QW  = 17;
    localparam logic [11:0] SMASK = 12'((32'd1 << ((SB < 12) ? SB : 12)) - 1);

    logic [11:0] xl_reg, xh_reg, yl_reg, yh_reg;
    logic [2:0]  orient_reg;
    logic [8:0]  alpha_reg;
    logic [15:0] pw_reg, ph_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xl_reg <= 12'd0; xh_reg <= 12'd4095;
            yl_reg <= 12'd0; yh_reg <= 12'd4095;
            orient_reg <= 3'd0; alpha_reg <= 9'd64;
            pw_reg <= 16'd3200; ph_reg <= 16'd3200;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                tpc_pkg::REG_X_LOW:  xl_reg <= cfg_data[11:0];
                tpc_pkg::REG_X_HIGH: xh_reg <= cfg_data[11:0];
                tpc_pkg::REG_Y_LOW:  yl_reg <= cfg_data[11:0];
                tpc_pkg::REG_Y_HIGH: yh_reg <= cfg_data[11:0];
                tpc_pkg::REG_ORIENT: orient_reg <= cfg_data[2:0];
                tpc_pkg::REG_ALPHA:  alpha_reg <= cfg_data[8:0];
                tpc_pkg::REG_WIDTH:  pw_reg <= cfg_data;
                tpc_pkg::REG_HEIGHT: ph_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            tpc_pkg::REG_X_LOW:  cfg_rdata = {20'd0, xl_reg};
            tpc_pkg::REG_X_HIGH: cfg_rdata = {20'd0, xh_reg};
            tpc_pkg::REG_Y_LOW:  cfg_rdata = {20'd0, yl_reg};
            tpc_pkg::REG_Y_HIGH: cfg_rdata = {20'd0, yh_reg};
            tpc_pkg::REG_ORIENT: cfg_rdata = {29'd0, orient_reg};
            tpc_pkg::REG_ALPHA:  cfg_rdata = {23'd0, alpha_reg};
            tpc_pkg::REG_WIDTH:  cfg_rdata = {16'd0, pw_reg};
            tpc_pkg::REG_HEIGHT: cfg_rdata = {16'd0, ph_reg};
            default:             cfg_rdata = 32'd0;
        endcase
    end

    // item and division state
    logic [1:0]  cmd_reg;
    logic [11:0] xs_reg, ys_reg;
    logic [12:0] spx_reg, spy_reg;                   // positive magnitudes
    logic [1:0]  satx_reg, saty_reg;                 // 0 div, 1 zero, 2 one
    logic [12:0] rx_reg, ry_reg;
    logic [QW-1:0] qx_reg, qy_reg;
    logic [4:0]  dcnt_reg;
    logic [15:0] px_reg, py_reg;
    logic [15:0] fx_reg, fy_reg;
    logic        seeded_reg;
    logic [CW-1:0] nb_reg;
    logic [CW-1:0] nb_count_reg;
    logic [CW-1:0] scan_reg;
    logic        match_reg;
    logic [15:0] bx_mem [BASELINE_SLOTS];
    logic [15:0] by_mem [BASELINE_SLOTS];
    logic [15:0] bx_rd_reg, by_rd_reg;
    logic        rd_vld_reg;

    function automatic logic [27:0] prep(input logic [11:0] s, input logic [11:0] lo,
                                         input logic [11:0] hi);
        logic signed [13:0] d, sp;
        logic [1:0] sat;
        begin
            d  = $signed({2'b0, s & SMASK}) - $signed({2'b0, lo & SMASK});
            sp = $signed({2'b0, hi & SMASK}) - $signed({2'b0, lo & SMASK});
            if (sp == 14'sd0) sp = 14'sd1;
            if (sp < 0)
            begin
                sp = -sp;
                d  = -d;
            end
            if (d <= 0) sat = 2'd1;
            else if (d >= sp) sat = 2'd2;
            else sat = 2'd0;
            prep = {sat, d[12:0], sp[12:0]};
        end
    endfunction

    logic [27:0] px_prep, py_prep;
    assign px_prep = prep(x_sample, xl_reg, xh_reg);
    assign py_prep = prep(y_sample, yl_reg, yh_reg);

    logic [13:0] rxs, rys;
    assign rxs = {rx_reg, 1'b0} - {1'b0, spx_reg};
    assign rys = {ry_reg, 1'b0} - {1'b0, spy_reg};

    logic [16:0] nx, ny, nx_o, ny_o;
    always_comb
    begin
        nx = (satx_reg == 2'd1) ? 17'd0 : (satx_reg == 2'd2) ? 17'h10000 : qx_reg;
        ny = (saty_reg == 2'd1) ? 17'd0 : (saty_reg == 2'd2) ? 17'h10000 : qy_reg;
        nx_o = orient_reg[2] ? ny : nx;
        ny_o = orient_reg[2] ? nx : ny;
        if (orient_reg[0]) nx_o = 17'h10000 - nx_o;
        if (orient_reg[1]) ny_o = 17'h10000 - ny_o;
    end

    logic [32:0] sx_prod, sy_prod;
    assign sx_prod = nx_o * pw_reg;
    assign sy_prod = ny_o * ph_reg;

    logic [8:0] a_eff;
    assign a_eff = (alpha_reg == 9'd0) ? 9'd1 : (alpha_reg > 9'd256) ? 9'd256 : alpha_reg;
    logic [25:0] smx, smy;
    assign smx = a_eff * px_reg + (9'd256 - a_eff) * fx_reg + 26'd128;
    assign smy = a_eff * py_reg + (9'd256 - a_eff) * fy_reg + 26'd128;

    logic [15:0] adx, ady;
    assign adx = (fx_reg > bx_rd_reg) ? fx_reg - bx_rd_reg : bx_rd_reg - fx_reg;
    assign ady = (fy_reg > by_rd_reg) ? fy_reg - by_rd_reg : by_rd_reg - fy_reg;
    logic hit;
    assign hit = rd_vld_reg && ({1'b0, adx} < 17'(MATCH_TOLERANCE))
                 && ({1'b0, ady} < 17'(MATCH_TOLERANCE));

    assign st.div_done  = (dcnt_reg == 5'd0);
    assign st.scan_done = (scan_reg >= nb_reg) && !rd_vld_reg;
    assign st.is_touch  = (cmd_reg == tpc_pkg::CMD_TOUCH);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cmd_reg  <= command;
            xs_reg   <= x_sample;
            ys_reg   <= y_sample;
            satx_reg <= px_prep[27:26];
            saty_reg <= py_prep[27:26];
            rx_reg   <= px_prep[25:13];
            ry_reg   <= py_prep[25:13];
            spx_reg  <= px_prep[12:0];
            spy_reg  <= py_prep[12:0];
            qx_reg   <= '0;
            qy_reg   <= '0;
            dcnt_reg <= 5'd16;
        end
        if (cmd.div_step)
        begin
            // restoring division, one quotient bit per axis
            if (!rxs[13])
            begin
                rx_reg <= rxs[12:0];
                qx_reg <= {qx_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rx_reg <= {rx_reg[11:0], 1'b0};
                qx_reg <= {qx_reg[QW-2:0], 1'b0};
            end
            if (!rys[13])
            begin
                ry_reg <= rys[12:0];
                qy_reg <= {qy_reg[QW-2:0], 1'b1};
            end
            else
            begin
                ry_reg <= {ry_reg[11:0], 1'b0};
                qy_reg <= {qy_reg[QW-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 5'd1;
        end
        if (cmd.do_scale)
        begin
            px_reg <= sx_prod[31:16];
            py_reg <= sy_prod[31:16];
        end
        if (cmd.scan_step)
        begin
            if (scan_reg < nb_reg)
            begin
                bx_rd_reg <= bx_mem[scan_reg[IW-1:0]];
                by_rd_reg <= by_mem[scan_reg[IW-1:0]];
            end
        end
        if (cmd.finish)
        begin
            case (cmd_reg)
                tpc_pkg::CMD_TOUCH:
                begin
                    valid_res <= !match_reg;
                    x_pos     <= fx_reg;
                    y_pos     <= fy_reg;
                    x_echo    <= xs_reg;
                    y_echo    <= ys_reg;
                    status    <= tpc_pkg::ST_OK;
                end
                tpc_pkg::CMD_ADD:
                begin
                    valid_res <= 1'b0;
                    x_pos     <= 16'd0;
                    y_pos     <= 16'd0;
                    x_echo    <= 12'd0;
                    y_echo    <= 12'd0;
                    if (!seeded_reg) status <= tpc_pkg::ST_NOSEED;
                    else if (nb_reg >= CW'(BASELINE_SLOTS)) status <= tpc_pkg::ST_FULL;
                    else
                    begin
                        status <= tpc_pkg::ST_OK;
                        bx_mem[nb_reg[IW-1:0]] <= fx_reg;
                        by_mem[nb_reg[IW-1:0]] <= fy_reg;
                    end
                end
                default:
                begin
                    valid_res <= 1'b0;
                    x_pos     <= 16'd0;
                    y_pos     <= 16'd0;
                    x_echo    <= 12'd0;
                    y_echo    <= 12'd0;
                    status    <= tpc_pkg::ST_OK;
                end
            endcase
        end
    end

    logic [CW-1:0] nb_after;
    always_comb
    begin
        nb_after = nb_reg;
        if (cmd_reg == tpc_pkg::CMD_CLEAR) nb_after = '0;
        else if (cmd_reg == tpc_pkg::CMD_ADD && seeded_reg
                 && nb_reg < CW'(BASELINE_SLOTS))
            nb_after = nb_reg + CW'(1);
    end
    assign baseline_count = 4'(nb_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg       <= 16'd0;
            fy_reg       <= 16'd0;
            seeded_reg   <= 1'b0;
            nb_reg       <= '0;
            nb_count_reg <= '0;
            scan_reg     <= '0;
            match_reg    <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_idx <= tpc_pkg::REG_HEIGHT)
                seeded_reg <= 1'b0;
            if (cmd.do_filt)
            begin
                if (!seeded_reg)
                begin
                    fx_reg <= px_reg;
                    fy_reg <= py_reg;
                end
                else
                begin
                    fx_reg <= smx[23:8];
                    fy_reg <= smy[23:8];
                end
                seeded_reg <= 1'b1;
                scan_reg   <= '0;
                match_reg  <= 1'b0;
                rd_vld_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (hit) match_reg <= 1'b1;
                rd_vld_reg <= (scan_reg < nb_reg);
                if (scan_reg < nb_reg) scan_reg <= scan_reg + CW'(1);
            end
            if (cmd.finish)
            begin
                if (cmd_reg == tpc_pkg::CMD_NONE) seeded_reg <= 1'b0;
                nb_reg       <= nb_after;
                nb_count_reg <= nb_after;
            end
        end
    end

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> dcnt_reg == 5'd16)
        else $error("division count not loaded");
    a_nb_range: assert property (@(posedge clk) disable iff (!rst_n)
        nb_reg <= CW'(BASELINE_SLOTS))
        else $error("baseline count overflow");
    a_seed_after_filt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_filt && !cfg_we |=> seeded_reg)
        else $error("filter not seeded");
endmodule
`default_nettype wire

[sv/touch_position_conditioner.sv]
// Touch position conditioner: controller state machine and datapath, one item at a time.
// Touched sample: 16-step division, scale, filter, then a scan of the N stored
// baselines; other commands go from the division state straight to the result.
// The next item is accepted only once the controller is back in idle, after the result
// is registered; a result still stalled holds the next one in the output state.
// Reset: rst_n asynchronous; config registers to defaults, filter empty, baseline list empty.
`default_nettype none
module touch_position_conditioner #(
    parameter int BASELINE_SLOTS  = tpc_pkg::BASELINE_SLOTS_DEF,
    parameter int SAMPLE_BITS     = tpc_pkg::SAMPLE_BITS_DEF,
    parameter int MATCH_TOLERANCE = tpc_pkg::MATCH_TOLERANCE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [11:0] x_sample,
    input  wire logic [11:0] y_sample,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             valid_res,
    output logic [15:0]      x_pos,
    output logic [15:0]      y_pos,
    output logic [11:0]      x_echo,
    output logic [11:0]      y_echo,
    output logic [1:0]       status,
    output logic [3:0]       baseline_count
);
    tpc_pkg::cmd_t  cmd;
    tpc_pkg::stat_t st;
    logic cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    tpc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .st(st), .cmd(cmd)
    );

    tpc_datapath #(
        .BASELINE_SLOTS(BASELINE_SLOTS),
        .SAMPLE_BITS(SAMPLE_BITS),
        .MATCH_TOLERANCE(MATCH_TOLERANCE)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .cfg_we(cfg_we), .cfg_idx(paddr[4:2]), .cfg_data(pwdata[15:0]),
        .cfg_rdata(prdata),
        .command(command), .x_sample(x_sample), .y_sample(y_sample),
        .valid_res(valid_res), .x_pos(x_pos), .y_pos(y_pos),
        .x_echo(x_echo), .y_echo(y_echo), .status(status),
        .baseline_count(baseline_count)
    );
endmodule
`default_nettype wire
